/* design/transposition_table_depth_preferred_defines.svh */
// Assertion macros for the transposition table design.
// Included by the RTL file that carries concurrent assertions; no other dependencies.
`ifndef TRANSPOSITION_TABLE_DEPTH_PREFERRED_DEFINES_SVH
`define TRANSPOSITION_TABLE_DEPTH_PREFERRED_DEFINES_SVH

`ifndef SYNTHESIS
// Checked property with reset disable, on the module's clk_i and rst_ni.
`define TTDP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked property that also holds while reset is asserted.
`define TTDP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define TTDP_ASSERT(lbl, prop, msg)
`define TTDP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* design/ttdp_pkg.sv */
// Types and constants shared by the transposition table design.
// No dependencies.
package ttdp_pkg;

  // Item modes.
  localparam logic [1:0] MODE_STORE_SCORE = 2'd0;
  localparam logic [1:0] MODE_STORE_MOVE  = 2'd1;
  localparam logic [1:0] MODE_PROBE_SCORE = 2'd2;
  localparam logic [1:0] MODE_PROBE_MOVE  = 2'd3;

  // Bound types.
  localparam logic [1:0] BOUND_NONE  = 2'd0;
  localparam logic [1:0] BOUND_EXACT = 2'd1;
  localparam logic [1:0] BOUND_ALPHA = 2'd2;
  localparam logic [1:0] BOUND_BETA  = 2'd3;

  // Configuration port.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-3:0] REG_INDEX_BITS = '0;
  localparam logic [3:0] INDEX_BITS_RESET = 4'd10;

  // One input word.
  typedef struct packed {
    logic [1:0]         mode;
    logic [63:0]        key;
    logic [7:0]         depth;
    logic signed [15:0] score;
    logic [1:0]         bound_type;
    logic [31:0]        best_move;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic               found;
    logic signed [15:0] result_value;
    logic [31:0]        result_move;
  } out_word_t;

  // One table entry.
  typedef struct packed {
    logic [63:0]        key;
    logic [7:0]         depth;
    logic signed [15:0] score;
    logic [1:0]         bound;
    logic [31:0]        move;
  } entry_t;

  // Table control states.
  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } tt_state_e;

endpackage

/* design/transposition_table_depth_preferred.sv */
// Depth-preferred direct-mapped transposition table with an APB-style config port.
// Depends on ttdp_pkg and transposition_table_depth_preferred_defines.svh.
//
//   Channel  Direction  Handshake                       Payload
//   in       sink       in_valid_i / in_ready_o         in_word_i  (ttdp_pkg::in_word_t)
//   out      source     out_valid_o / out_ready_i       out_word_o (ttdp_pkg::out_word_t)
//   cfg      APB slave  psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// One word is accepted per cycle unless the sweep runs or the second stage is held;
// a probe's entry is read into a register, then its answer into the output register.
// After reset the memory is swept to zero, with in_ready_o low.
// A store in the second stage writes its read entry back, modified, if not shallower;
// a store to the entry read by the word behind it is forwarded to that word.
// A full output register that is not read holds a probe in the second stage, and input.
`include "transposition_table_depth_preferred_defines.svh"

module transposition_table_depth_preferred #(
  parameter int unsigned INDEX_BITS = 10
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  ttdp_pkg::in_word_t                     in_word_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output ttdp_pkg::out_word_t                    out_word_o,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [ttdp_pkg::CFG_ADDR_W-1:0]        paddr,
  input  logic [ttdp_pkg::CFG_DATA_W-1:0]        pwdata,
  output logic [ttdp_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                   pready
);

  localparam int unsigned TABLE_DEPTH = 1 << INDEX_BITS;

  ttdp_pkg::tt_state_e state_q, state_d;
  logic [INDEX_BITS-1:0] clr_addr_q, clr_addr_d;
  logic [3:0] index_bits_q;
  logic cfg_wr;

  ttdp_pkg::entry_t mem_q [TABLE_DEPTH];
  ttdp_pkg::entry_t rd_data_q;
  ttdp_pkg::entry_t fwd_data_q;
  logic [INDEX_BITS-1:0] rd_slot;

  logic in_acc;
  logic s1_valid_q;
  logic s1_fwd_q;
  ttdp_pkg::in_word_t s1_word_q;
  logic [INDEX_BITS-1:0] s1_slot_q;
  logic s1_is_store;
  logic s1_adv;
  ttdp_pkg::entry_t s1_entry;
  ttdp_pkg::entry_t s1_new_entry;
  logic store_ok;

  logic wr_en;
  logic [INDEX_BITS-1:0] wr_addr;
  ttdp_pkg::entry_t wr_data;

  logic out_valid_q;
  ttdp_pkg::out_word_t out_word_q, probe_res;

  // Configuration register: writes on the access phase, reads are combinational.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[ttdp_pkg::CFG_ADDR_W-1:2] == ttdp_pkg::REG_INDEX_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_bits_q <= ttdp_pkg::INDEX_BITS_RESET;
    end else if (cfg_wr) begin
      index_bits_q <= pwdata[3:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[ttdp_pkg::CFG_ADDR_W-1:2] == ttdp_pkg::REG_INDEX_BITS) begin
      prdata[3:0] = index_bits_q;
    end
  end

  // Clear sweep after reset, then normal operation.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ttdp_pkg::ST_CLEAR;
      clr_addr_q <= '0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ttdp_pkg::ST_CLEAR: begin
        clr_addr_d = clr_addr_q + INDEX_BITS'(1);
        if (&clr_addr_q) begin
          state_d = ttdp_pkg::ST_RUN;
        end
      end
      ttdp_pkg::ST_RUN: begin
        in_ready_o = !s1_valid_q || s1_adv;
      end
      default: begin
        state_d = ttdp_pkg::ST_CLEAR;
      end
    endcase
  end

  assign in_acc = in_valid_i && in_ready_o;

  // Slot of the incoming key: low key bits up to the configured width.
  always_comb begin
    rd_slot = '0;
    for (int b = 0; b < INDEX_BITS; b++) begin
      rd_slot[b] = in_word_i.key[b] && (b < int'(index_bits_q));
    end
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (in_acc) begin
      rd_data_q <= mem_q[rd_slot];
    end
  end

  // Last written entry, used when the read raced the write of the same slot.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fwd_data_q <= wr_data;
    end
  end

  // Second stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_fwd_q   <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
      s1_fwd_q   <= wr_en && (wr_addr == rd_slot);
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_word_q <= in_word_i;
      s1_slot_q <= rd_slot;
    end
  end

  assign s1_entry    = s1_fwd_q ? fwd_data_q : rd_data_q;
  assign s1_is_store = (s1_word_q.mode == ttdp_pkg::MODE_STORE_SCORE) ||
                       (s1_word_q.mode == ttdp_pkg::MODE_STORE_MOVE);
  assign s1_adv      = s1_valid_q && (s1_is_store || !out_valid_q || out_ready_i);
  assign store_ok    = s1_entry.depth <= s1_word_q.depth;

  // Modified entry for a store: key and depth always, then score and bound, or move.
  always_comb begin
    s1_new_entry       = s1_entry;
    s1_new_entry.key   = s1_word_q.key;
    s1_new_entry.depth = s1_word_q.depth;
    if (s1_word_q.mode == ttdp_pkg::MODE_STORE_SCORE) begin
      s1_new_entry.score = s1_word_q.score;
      s1_new_entry.bound = s1_word_q.bound_type;
    end else begin
      s1_new_entry.move = s1_word_q.best_move;
    end
  end

  // Write port shared by the clear sweep and stores.
  always_comb begin
    if (state_q == ttdp_pkg::ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_q;
      wr_data = '0;
    end else begin
      wr_en   = s1_valid_q && s1_is_store && store_ok;
      wr_addr = s1_slot_q;
      wr_data = s1_new_entry;
    end
  end

  // Probe answer.
  always_comb begin
    probe_res = '0;
    if (s1_word_q.mode == ttdp_pkg::MODE_PROBE_MOVE) begin
      if (s1_entry.key == s1_word_q.key) begin
        probe_res.found       = 1'b1;
        probe_res.result_move = s1_entry.move;
      end
    end else if ((s1_entry.key == s1_word_q.key) && (s1_entry.depth >= s1_word_q.depth)) begin
      unique case (s1_entry.bound)
        ttdp_pkg::BOUND_EXACT: begin
          probe_res.found        = 1'b1;
          probe_res.result_value = s1_entry.score;
        end
        ttdp_pkg::BOUND_ALPHA: begin
          if (s1_entry.score <= s1_word_q.alpha) begin
            probe_res.found        = 1'b1;
            probe_res.result_value = s1_word_q.alpha;
          end
        end
        ttdp_pkg::BOUND_BETA: begin
          if (s1_entry.score >= s1_word_q.beta) begin
            probe_res.found        = 1'b1;
            probe_res.result_value = s1_word_q.beta;
          end
        end
        default: begin
          probe_res.found = 1'b0;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && !s1_is_store) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && !s1_is_store) begin
      out_word_q <= probe_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // No word enters while the memory is being cleared.
  `TTDP_ASSERT_ALWAYS(a_no_accept_in_clear,
                      (state_q == ttdp_pkg::ST_CLEAR) |-> !in_ready_o,
                      "word accepted during clear sweep")
  // A new answer only comes from a probe in the second stage.
  `TTDP_ASSERT(a_answer_from_probe,
               $rose(out_valid_q) |-> $past(s1_valid_q && !s1_is_store),
               "answer without a probe")
  // The memory is written only by the sweep or by a store in the second stage.
  `TTDP_ASSERT(a_write_source,
               wr_en |-> ((state_q == ttdp_pkg::ST_CLEAR) || (s1_valid_q && s1_is_store)),
               "unexpected memory write")
  // A read that races a write of the same slot takes the forwarded entry.
  `TTDP_ASSERT(a_forward_taken,
               (in_acc && wr_en && (wr_addr == rd_slot)) |=> s1_fwd_q,
               "missed forwarding")

endmodule

/* tb/transposition_table_checker.sv */
// Checker for the transposition table: watches the word channels and the config port,
// keeps its own copy of the table, predicts every probe answer and compares it.
// Depends on ttdp_pkg.
module transposition_table_checker
  import ttdp_pkg::*;
#(
  parameter int unsigned INDEX_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_word_t              in_word_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_word_t             out_word_i,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic                  pready,
  output int                    mismatches_o,
  output int                    answers_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_ENTRIES = 2 ** INDEX_BITS;

  entry_t      entries [NUM_ENTRIES];
  logic [3:0]  index_bits_q;
  out_word_t   answers_due [$];
  int          mismatches = 0;

  assign mismatches_o      = mismatches;
  assign answers_pending_o = answers_due.size();

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Table slot of a key under the current index width, saturated at the table size.
  function automatic int unsigned slot_of_key(input logic [63:0] key);
    int unsigned bits;
    logic [63:0] mask;
    bits = (index_bits_q > INDEX_BITS) ? INDEX_BITS : index_bits_q;
    mask = (bits == 0) ? 64'd0 : ((64'd1 << bits) - 64'd1);
    return int'(key & mask);
  endfunction

  // Apply one accepted word to the table copy; probes queue the answer they must give.
  task automatic lookup_and_update(input in_word_t w);
    int unsigned        s;
    entry_t             e;
    out_word_t          ans;
    logic signed [15:0] stored;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    s      = slot_of_key(w.key);
    e      = entries[s];
    ans    = '0;
    stored = e.score;
    lo     = w.alpha;
    hi     = w.beta;
    case (w.mode)
      MODE_STORE_SCORE, MODE_STORE_MOVE: begin
        // Depth-preferred replacement: equal or deeper searches overwrite.
        if (e.depth <= w.depth) begin
          e.key   = w.key;
          e.depth = w.depth;
          if (w.mode == MODE_STORE_SCORE) begin
            e.score = w.score;
            e.bound = w.bound_type;
          end else begin
            e.move = w.best_move;
          end
          entries[s] = e;
        end
      end
      MODE_PROBE_SCORE: begin
        if (e.key == w.key && e.depth >= w.depth) begin
          if (e.bound == BOUND_EXACT) begin
            ans.found        = 1'b1;
            ans.result_value = stored;
          end else if (e.bound == BOUND_ALPHA && stored <= lo) begin
            ans.found        = 1'b1;
            ans.result_value = lo;
          end else if (e.bound == BOUND_BETA && stored >= hi) begin
            ans.found        = 1'b1;
            ans.result_value = hi;
          end
        end
        answers_due.push_back(ans);
      end
      default: begin
        if (e.key == w.key) begin
          ans.found       = 1'b1;
          ans.result_move = e.move;
        end
        answers_due.push_back(ans);
      end
    endcase
  endtask

  // Compare one accepted result word against the oldest predicted answer.
  task automatic check_answer(input out_word_t got);
    out_word_t exp;
    if (answers_due.size() == 0) begin
      report_mismatch($sformatf("result word with no answer due: %p", got));
    end else begin
      exp = answers_due.pop_front();
      if (got.found !== exp.found) begin
        report_mismatch($sformatf("found %b, expected %b", got.found, exp.found));
      end
      if (got.result_value !== exp.result_value) begin
        report_mismatch($sformatf("result_value %0d, expected %0d",
                                  got.result_value, exp.result_value));
      end
      if (got.result_move !== exp.result_move) begin
        report_mismatch($sformatf("result_move %h, expected %h",
                                  got.result_move, exp.result_move));
      end
    end
  endtask

  // Results are checked before the same edge's input word; a word's answer is never
  // accepted at the edge that accepts the word itself.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        entries[i] = '0;
      end
      index_bits_q = INDEX_BITS_RESET;
      answers_due.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        check_answer(out_word_i);
      end
      if (psel && penable && pwrite && pready && paddr[CFG_ADDR_W-1:2] == REG_INDEX_BITS) begin
        index_bits_q = pwdata[3:0];
      end
      if (in_valid_i && in_ready_i) begin
        lookup_and_update(in_word_i);
      end
    end
  end

endmodule

/* tb/tb_transposition_table_depth_preferred.sv */
// Testbench top for the transposition table: clock, reset, config writes, directed and
// random words with random idling on both channels, and the final verdict.
// Depends on ttdp_pkg, transposition_table_depth_preferred and transposition_table_checker.
module tb_transposition_table_depth_preferred;
  import ttdp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned INDEX_BITS   = 10;
  localparam int unsigned NUM_PHASES   = 10;
  localparam int unsigned PHASE_WORDS  = 140;
  localparam int unsigned LONG_HOLD    = 300;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid;
  logic                  in_ready;
  in_word_t              in_word;
  logic                  out_valid;
  logic                  out_ready;
  out_word_t             out_word;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    mismatches;
  int                    answers_pending;
  bit                    quiet;
  int                    hold_requests;
  int                    holds_done;
  logic [63:0]           key_pool [8];

  transposition_table_depth_preferred #(
    .INDEX_BITS(INDEX_BITS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (out_word),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  transposition_table_checker #(
    .INDEX_BITS(INDEX_BITS)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_word_i        (in_word),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_word_i       (out_word),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .mismatches_o     (mismatches),
    .answers_pending_o(answers_pending)
  );

  // 20 ns clock.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  // Result side: random ready bursts, one long hold on request, always ready when quiet.
  initial begin
    int n;
    out_ready  <= 1'b0;
    holds_done = 0;
    @(posedge clk_i);
    forever begin
      if (hold_requests != holds_done) begin
        holds_done++;
        out_ready <= 1'b0;
        n = LONG_HOLD;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 6);
      end else begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 12);
      end
      repeat (n) @(posedge clk_i);
    end
  end

  function automatic in_word_t make_word(input logic [1:0] mode, input logic [63:0] key,
                                         input logic [7:0] depth, input logic [15:0] score,
                                         input logic [1:0] bound, input logic [31:0] move,
                                         input logic [15:0] alpha, input logic [15:0] beta);
    in_word_t w;
    w.mode       = mode;
    w.key        = key;
    w.depth      = depth;
    w.score      = score;
    w.bound_type = bound;
    w.best_move  = move;
    w.alpha      = alpha;
    w.beta       = beta;
    return w;
  endfunction

  // Offer one word, maybe after an idle burst, and return at the edge that accepts it.
  // Called right after a rising edge; valid is left high for a back-to-back word.
  task automatic offer_word(input in_word_t w);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  // Stop offering and wait until every answer is in and the last store has retired.
  task automatic drain_words();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (answers_pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write of the index width: setup cycle, then access cycle.
  task automatic write_index_bits(input logic [3:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_INDEX_BITS, 2'b00};
    pwdata  <= {28'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Few slots and few high parts, so keys collide and stores land on probed entries.
  task automatic refill_key_pool(input bit with_zero);
    logic [9:0]  slots [3];
    logic [53:0] highs [3];
    for (int i = 0; i < 3; i++) begin
      slots[i] = 10'($urandom);
      highs[i] = {22'($urandom), $urandom};
    end
    for (int i = 0; i < 8; i++) begin
      key_pool[i] = {highs[$urandom_range(0, 2)], slots[$urandom_range(0, 2)]};
    end
    if (with_zero) begin
      key_pool[0] = '0;
    end
  endtask

  function automatic logic [15:0] window_value();
    logic signed [15:0] v;
    case ($urandom_range(0, 4))
      0:       v = 16'($urandom);
      1:       v = ($urandom_range(0, 1) == 0) ? 16'sh8000 : 16'sh7fff;
      default: v = 16'($urandom_range(0, 20)) - 16'sd10;
    endcase
    return v;
  endfunction

  // Mostly pool keys with shallow depths and scores near the window; some full noise.
  function automatic in_word_t random_word();
    logic [63:0] key;
    logic [7:0]  depth;
    key   = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : key_pool[$urandom_range(0, 7)];
    depth = ($urandom_range(0, 31) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    return make_word(2'($urandom), key, depth, window_value(), 2'($urandom), $urandom,
                     window_value(), window_value());
  endfunction

  // Stimulus and verdict.
  initial begin
    logic [63:0] k1;
    logic [63:0] k1_alias;
    logic [63:0] k2;
    logic [63:0] kmax;
    logic [3:0]  widths [NUM_PHASES];
    rst_ni        = 1'b0;
    in_valid      = 1'b0;
    in_word       = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    quiet         = 1'b0;
    hold_requests = 0;
    k1       = 64'h0123_4567_89ab_c005;
    k1_alias = 64'hfedc_0000_0000_0005;
    k2       = 64'h5555_aaaa_0f0f_0009;
    kmax     = 64'hffff_ffff_ffff_ffff;
    widths   = '{4'd10, 4'd0, 4'd1, 4'd15, 4'd3, 4'd2, 4'd6, 4'd10, 4'd4, 4'd1};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed words under the reset index width.
    offer_word(make_word(MODE_PROBE_MOVE, '0, 8'd0, '0, BOUND_NONE, '0, '0, '0));
    offer_word(make_word(MODE_PROBE_SCORE, '0, 8'd0, '0, BOUND_NONE, '0, '0, '0));
    offer_word(make_word(MODE_STORE_SCORE, k1, 8'd5, 16'sh7fff, BOUND_EXACT, '0, '0, '0));
    offer_word(make_word(MODE_PROBE_SCORE, k1, 8'd5, '0, BOUND_NONE, '0, '0, '0));
    offer_word(make_word(MODE_PROBE_SCORE, k1, 8'd6, '0, BOUND_NONE, '0, '0, '0));
    // A shallower store must not replace the entry.
    offer_word(make_word(MODE_STORE_SCORE, k1, 8'd4, 16'shffff, BOUND_EXACT, '0, '0, '0));
    offer_word(make_word(MODE_PROBE_SCORE, k1, 8'd0, '0, BOUND_NONE, '0, '0, '0));
    offer_word(make_word(MODE_STORE_MOVE, k1, 8'd5, '0, BOUND_NONE, 32'hffff_ffff, '0, '0));
    offer_word(make_word(MODE_PROBE_MOVE, k1, 8'd0, '0, BOUND_NONE, '0, '0, '0));
    // A move store under another key keeps the old score and bound.
    offer_word(make_word(MODE_STORE_MOVE, k1_alias, 8'd5, '0, BOUND_NONE, '0, '0, '0));
    offer_word(make_word(MODE_PROBE_SCORE, k1_alias, 8'd5, '0, BOUND_NONE, '0, '0, '0));
    offer_word(make_word(MODE_PROBE_MOVE, k1, 8'd0, '0, BOUND_NONE, '0, '0, '0));
    offer_word(make_word(MODE_STORE_SCORE, kmax, 8'hff, 16'sh8000, BOUND_ALPHA,
                         '0, 16'sh7fff, 16'sh8000));
    offer_word(make_word(MODE_PROBE_SCORE, kmax, 8'hff, '0, BOUND_NONE, '0,
                         16'sh8000, 16'sh7fff));
    offer_word(make_word(MODE_STORE_SCORE, k2, 8'd0, 16'sd100, BOUND_ALPHA, '0, '0, '0));
    offer_word(make_word(MODE_PROBE_SCORE, k2, 8'd0, '0, BOUND_NONE, '0, 16'sd99, '0));
    offer_word(make_word(MODE_PROBE_SCORE, k2, 8'd0, '0, BOUND_NONE, '0, 16'sd100, '0));
    offer_word(make_word(MODE_STORE_SCORE, k2, 8'd0, -16'sd5, BOUND_BETA, '0, '0, '0));
    offer_word(make_word(MODE_PROBE_SCORE, k2, 8'd0, '0, BOUND_NONE, '0, '0, -16'sd5));
    offer_word(make_word(MODE_PROBE_SCORE, k2, 8'd0, '0, BOUND_NONE, '0, '0, 16'sh7fff));
    // An entry with no bound never answers a score probe.
    offer_word(make_word(MODE_STORE_SCORE, k2, 8'd1, 16'sd7, BOUND_NONE, '0, '0, '0));
    offer_word(make_word(MODE_PROBE_SCORE, k2, 8'd0, '0, BOUND_NONE, '0, 16'sh7fff, '0));
    // A score store leaves the move as it was.
    offer_word(make_word(MODE_PROBE_MOVE, kmax, 8'd0, '0, BOUND_NONE, '0, '0, '0));
    drain_words();

    // Random phases, each under its own index width; the last one runs without idling.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_index_bits(widths[p]);
      refill_key_pool(p % 3 == 0);
      quiet = (p == NUM_PHASES - 1);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (p == 1 && i == 40) begin
          hold_requests <= hold_requests + 1;
        end
        offer_word(random_word());
      end
      drain_words();
    end

    // Wait out any answer still due, then give the verdict.
    for (int n = 0; n < 20000 && answers_pending != 0; n++) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && answers_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/ttdp_pkg.sv
design/transposition_table_depth_preferred.sv
tb/transposition_table_checker.sv
tb/tb_transposition_table_depth_preferred.sv
